// ===== design/tccw_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tccw_pkg
// Shared constants, codes and control types for the text console writer.
// ---------------------------------------------------------------------------
package tccw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LAST_ROW   = CELL_COUNT - COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CUR_W  = $clog2(CELL_COUNT + 1);
  localparam int COL_W  = $clog2(COLUMNS);

  // stream field widths
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int RIDX_W  = 11;
  localparam int POS_W   = 11;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = CHAR_W + ATTR_W;

  localparam int IN_DATA_W  = ((CHAR_W + RIDX_W + 7) / 8) * 8;
  localparam int OUT_BITS   = POS_W + CHAR_W + ATTR_W + 2;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_COLON     = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'h07;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // latch a new item, issue its cell read
    logic finish;       // final update and result load
    logic cnt_init_clr;
    logic cnt_init_cp;
    logic cnt_init_fl;
    logic clr_step;     // blank one cell of the full screen
    logic cp_step;      // one step of the row copy
    logic fl_step;      // blank one cell of the bottom row
  } tccw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_clear;
    logic need_scroll;
    logic cnt_last;     // counter on the last cell
    logic cnt_end;      // counter one past the last cell
    logic out_free;
  } tccw_stat_t;

endpackage
`default_nettype wire

// ===== design/text_console_char_writer_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// text_console_char_writer_unit
// Character-cell text console: 80x25 cells of character plus attribute.
// ---------------------------------------------------------------------------
// Input stream: one command per beat (put character, read cell, clear).
// Output stream: one result beat per command with the new cursor position,
// the cell read, and scrolled / refused flags.
// cfg_wr_en / cfg_wr_data set the attribute used for printed characters and
// backspace blanks; write it only while the unit is idle.
//
// An ordinary command: the accept cycle issues the cell read, then the S_EXEC
// state updates the cell and loads the output register. The unit takes one
// command at a time, so a new command is accepted only once the last one has
// been loaded into the output register.
// A scroll first copies the rows up (one cell a cycle), then blanks the bottom
// row; a clear blanks the full screen.
// After reset all CELL_COUNT (2000) cells are blanked, during which in_tready
// stays low. A result waiting on a stalled receiver does not block the
// next accept; that item then holds before its result until out_tready.
// ---------------------------------------------------------------------------
module text_console_char_writer_unit
  import tccw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // char_code, read_index
  input  wire logic [CMD_W-1:0]      in_tuser,   // command
  // result
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // cursor_pos, cell_char,
                                                 // cell_attr, scrolled, refused
  // attribute register
  input  wire logic                  cfg_wr_en,
  input  wire logic [ATTR_W-1:0]     cfg_wr_data
);

  tccw_cmd_t  cmd;
  tccw_stat_t stat;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tccw_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_command  (in_tuser),
    .in_char     (in_tdata[CHAR_W-1:0]),
    .in_ridx     (in_tdata[CHAR_W+RIDX_W-1:CHAR_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_data    (out_tdata)
  );

endmodule
`default_nettype wire

// ===== design/tccw_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tccw_dp
// Datapath: cell store, cursor, sweep counter, attribute register and the
// result register.
// ---------------------------------------------------------------------------
module tccw_dp
  import tccw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tccw_cmd_t             cmd,
  output tccw_stat_t                 stat,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [CHAR_W-1:0]     in_char,
  input  wire logic [RIDX_W-1:0]     in_ridx,
  input  wire logic                  cfg_wr_en,
  input  wire logic [ATTR_W-1:0]     cfg_wr_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [OUT_DATA_W-1:0]      out_data
);

  logic [CELL_W-1:0] cell_mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [CHAR_W-1:0] code_r;
  logic [RIDX_W-1:0] ridx_r;
  logic [ATTR_W-1:0] attr_r;

  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CUR_W-1:0]  cnt_r, cnt_nxt;
  logic              swept_r, swept_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] cp_wa_r;

  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  o_pos_r, o_pos_nxt;
  logic [CHAR_W-1:0] o_char_r, o_char_nxt;
  logic [ATTR_W-1:0] o_attr_r, o_attr_nxt;
  logic              o_scr_r, o_scr_nxt;
  logic              o_ref_r, o_ref_nxt;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data;

  logic              is_nl, is_bs, is_pr;
  logic [CUR_W-1:0]  base;
  logic [CUR_W-1:0]  put_addr;
  logic              ridx_ok;
  logic              in_ridx_ok;
  logic [COL_W-1:0]  col_inc, col_dec;

  assign is_nl      = (cmd_r == CMD_PUT) && (code_r == CH_NEWLINE);
  assign is_bs      = (cmd_r == CMD_PUT) && (code_r == CH_BACKSPACE);
  assign is_pr      = (cmd_r == CMD_PUT) && !is_nl && !is_bs;
  assign base       = cursor_r - CUR_W'(col_r);
  assign ridx_ok    = (32'(ridx_r) < 32'(CELL_COUNT));
  assign in_ridx_ok = (32'(in_ridx) < 32'(CELL_COUNT));
  assign put_addr   = swept_r ? CUR_W'(LAST_ROW) : cursor_r;
  assign col_inc    = (col_r == COL_W'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
  assign col_dec    = (col_r == '0) ? COL_W'(COLUMNS - 1) : col_r - 1'b1;

  always_comb begin
    stat.need_clear  = (cmd_r == CMD_CLEAR) && !swept_r;
    stat.need_scroll = !swept_r &&
                       ((is_nl && (base >= CUR_W'(LAST_ROW))) ||
                        (is_pr && (cursor_r == CUR_W'(CELL_COUNT))));
    stat.cnt_last    = (cnt_r == CUR_W'(CELL_COUNT - 1));
    stat.cnt_end     = (cnt_r == CUR_W'(CELL_COUNT));
    stat.out_free    = !out_valid_r || out_ready;
  end

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    cursor_nxt    = cursor_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    swept_nxt     = swept_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    o_pos_nxt     = o_pos_r;
    o_char_nxt    = o_char_r;
    o_attr_nxt    = o_attr_r;
    o_scr_nxt     = o_scr_r;
    o_ref_nxt     = o_ref_r;

    // read port
    if (cmd.accept) begin
      swept_nxt = 1'b0;
      if (in_command == CMD_READ) begin
        rd_en   = in_ridx_ok;
        rd_addr = ADDR_W'(in_ridx);
      end else begin
        // cell left of the cursor, for the backspace colon check
        rd_en   = (cursor_r != '0);
        rd_addr = ADDR_W'(cursor_r - 1'b1);
      end
    end else if (cmd.cp_step && !stat.cnt_end) begin
      rd_en    = 1'b1;
      rd_addr  = ADDR_W'(cnt_r);
      pend_nxt = 1'b1;
    end

    // sweep counter
    if (cmd.cnt_init_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_init_cp) begin
      cnt_nxt = CUR_W'(COLUMNS);
    end else if (cmd.cnt_init_fl) begin
      cnt_nxt = CUR_W'(LAST_ROW);
    end else if (cmd.clr_step || cmd.cp_step || cmd.fl_step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if ((cmd.clr_step || cmd.fl_step) && stat.cnt_last) begin
      swept_nxt = 1'b1;
    end

    // write port: a copy write follows its read in the next cycle
    if (pend_r) begin
      wr_en   = 1'b1;
      wr_addr = cp_wa_r;
      wr_data = rd_data_r;
    end else if (cmd.clr_step || cmd.fl_step) begin
      wr_en   = 1'b1;
      wr_addr = ADDR_W'(cnt_r);
      wr_data = {BLANK_ATTR, CH_BLANK};
    end

    if (cmd.finish) begin
      o_char_nxt = '0;
      o_attr_nxt = '0;
      o_ref_nxt  = 1'b0;
      o_scr_nxt  = swept_r && (cmd_r == CMD_PUT);
      case (cmd_r)
        CMD_PUT: begin
          if (is_nl) begin
            cursor_nxt = swept_r ? base : base + CUR_W'(COLUMNS);
            col_nxt    = '0;
          end else if (is_bs) begin
            if ((cursor_r == '0) || (rd_data_r[CHAR_W-1:0] == CH_COLON)) begin
              o_ref_nxt = 1'b1;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = ADDR_W'(cursor_r - 1'b1);
              wr_data    = {attr_r, CH_BLANK};
              cursor_nxt = cursor_r - 1'b1;
              col_nxt    = col_dec;
            end
          end else begin
            wr_en      = 1'b1;
            wr_addr    = ADDR_W'(put_addr);
            wr_data    = {attr_r, code_r};
            cursor_nxt = put_addr + 1'b1;
            col_nxt    = swept_r ? COL_W'(1) : col_inc;
          end
        end
        CMD_READ: begin
          if (ridx_ok) begin
            o_char_nxt = rd_data_r[CHAR_W-1:0];
            o_attr_nxt = rd_data_r[CELL_W-1:CHAR_W];
          end
        end
        CMD_CLEAR: begin
          cursor_nxt = '0;
          col_nxt    = '0;
        end
        default: begin
        end
      endcase
      o_pos_nxt     = POS_W'(cursor_nxt);
      out_valid_nxt = 1'b1;
    end
  end

  // cell store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= cell_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= in_command;
      code_r <= in_char;
      ridx_r <= in_ridx;
    end
    if (pend_nxt) begin
      cp_wa_r <= ADDR_W'(cnt_r - CUR_W'(COLUMNS));
    end
    o_pos_r  <= o_pos_nxt;
    o_char_r <= o_char_nxt;
    o_attr_r <= o_attr_nxt;
    o_scr_r  <= o_scr_nxt;
    o_ref_r  <= o_ref_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      cursor_r    <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      swept_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      swept_r     <= swept_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = OUT_DATA_W'({o_ref_r, o_scr_r, o_attr_r, o_char_r, o_pos_r});

endmodule
`default_nettype wire

// ===== design/tccw_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tccw_ctrl
// Controller: sequences the reset clear, item execution, screen clear and
// scroll sweeps of the console datapath.
// ---------------------------------------------------------------------------
module tccw_ctrl
  import tccw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tccw_stat_t stat,
  output tccw_cmd_t       cmd
);

  localparam logic [2:0] S_RST_CLR = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_EXEC    = 3'd2;
  localparam logic [2:0] S_CLR     = 3'd3;
  localparam logic [2:0] S_CP      = 3'd4;
  localparam logic [2:0] S_FL      = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_RST_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.need_clear) begin
          cmd.cnt_init_clr = 1'b1;
          state_nxt        = S_CLR;
        end else if (stat.need_scroll) begin
          cmd.cnt_init_cp = 1'b1;
          state_nxt       = S_CP;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_CP: begin
        if (stat.cnt_end) begin
          // last copy write drains this cycle
          cmd.cnt_init_fl = 1'b1;
          state_nxt       = S_FL;
        end else begin
          cmd.cp_step = 1'b1;
        end
      end
      S_FL: begin
        cmd.fl_step = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_EXEC;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== test/tccw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tccw_checker
// Watches the command, result and attribute ports of the text console writer.
// It keeps its own copy of the screen, cursor and attribute, works out the
// result of every accepted command, and compares each result beat field by
// field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module tccw_checker
  import tccw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // char_code, read_index
  input  wire logic [CMD_W-1:0]      in_tuser,   // command
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,  // cursor_pos, cell_char,
                                                 // cell_attr, scrolled, refused
  input  wire logic                  cfg_wr_en,
  input  wire logic [ATTR_W-1:0]     cfg_wr_data,
  output int                         pending,
  output int                         err_count
);

  localparam int CH_LO   = POS_W;
  localparam int AT_LO   = POS_W + CHAR_W;
  localparam int SCR_BIT = POS_W + CHAR_W + ATTR_W;
  localparam int REF_BIT = SCR_BIT + 1;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic              scrolled;
    logic              refused;
  } console_result_t;

  logic [CHAR_W-1:0] shadow_ch [CELL_COUNT];
  logic [ATTR_W-1:0] shadow_at [CELL_COUNT];
  int                cursor;
  logic [ATTR_W-1:0] attr_reg;
  console_result_t   due_q [$];
  int                mism = 0;

  task automatic blank_cells(input int from, input int count);
    for (int i = from; i < from + count; i++) begin
      shadow_ch[i] = CH_BLANK;
      shadow_at[i] = BLANK_ATTR;
    end
  endtask

  task automatic shift_rows_up();
    for (int i = 0; i < LAST_ROW; i++) begin
      shadow_ch[i] = shadow_ch[i + COLUMNS];
      shadow_at[i] = shadow_at[i + COLUMNS];
    end
    blank_cells(LAST_ROW, COLUMNS);
  endtask

  // Updates the shadow screen for one command and returns the result it causes.
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] code,
                               input logic [RIDX_W-1:0] ridx, output console_result_t r);
    int nxt;
    r = '0;
    case (cmd)
      CMD_PUT: begin
        if (code == CH_NEWLINE) begin
          nxt = (cursor / COLUMNS) * COLUMNS + COLUMNS;
          if (nxt >= CELL_COUNT) begin
            shift_rows_up();
            r.scrolled = 1'b1;
            nxt -= COLUMNS;
          end
          cursor = nxt;
        end else if (code == CH_BACKSPACE) begin
          if (cursor == 0 || shadow_ch[cursor - 1] == CH_COLON) begin
            r.refused = 1'b1;
          end else begin
            cursor--;
            shadow_ch[cursor] = CH_BLANK;
            shadow_at[cursor] = attr_reg;
          end
        end else begin
          // past the end: scroll first, then print on the bottom row
          if (cursor >= CELL_COUNT) begin
            shift_rows_up();
            r.scrolled = 1'b1;
            cursor = LAST_ROW;
          end
          shadow_ch[cursor] = code;
          shadow_at[cursor] = attr_reg;
          cursor++;
        end
      end
      CMD_READ: begin
        if (ridx < CELL_COUNT) begin
          r.ch   = shadow_ch[ridx];
          r.attr = shadow_at[ridx];
        end
      end
      CMD_CLEAR: begin
        blank_cells(0, CELL_COUNT);
        cursor = 0;
      end
      default: ;
    endcase
    r.pos = cursor[POS_W-1:0];
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mism++;
    end
  endtask

  always @(posedge clk) begin
    console_result_t res;
    if (!rst_n) begin
      blank_cells(0, CELL_COUNT);
      cursor   = 0;
      attr_reg = ATTR_RESET;
      due_q.delete();
    end else begin
      // a result beat always belongs to an older command than a same-edge input
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
          mism++;
        end else begin
          res = due_q.pop_front();
          check_field("cursor_pos", 32'(res.pos), 32'(out_tdata[POS_W-1:0]));
          check_field("cell_char", 32'(res.ch), 32'(out_tdata[CH_LO +: CHAR_W]));
          check_field("cell_attr", 32'(res.attr), 32'(out_tdata[AT_LO +: ATTR_W]));
          check_field("scrolled", 32'(res.scrolled), 32'(out_tdata[SCR_BIT]));
          check_field("refused", 32'(res.refused), 32'(out_tdata[REF_BIT]));
        end
      end
      if (cfg_wr_en) begin
        attr_reg = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        apply_command(in_tuser, in_tdata[CHAR_W-1:0], in_tdata[CHAR_W +: RIDX_W], res);
        due_q.push_back(res);
      end
    end
    pending   <= due_q.size();
    err_count <= mism;
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the text console writer.
// A short directed sequence covers reads in and out of range, refused
// backspaces, newlines, the unused command and a clear; random bursts of text
// lines, full rows, backspaces, reads and noise follow, under several
// attribute settings and random idling on both streams.
// ---------------------------------------------------------------------------
module tb;
  import tccw_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam int               ITEM_COUNT  = 1450;
  localparam int               PHASES      = 6;
  localparam int               STALL_LIMIT = 12000;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [CMD_W-1:0]      in_tuser    = CMD_PUT;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en   = 1'b0;
  logic [ATTR_W-1:0]     cfg_wr_data = '0;
  logic                  steady      = 1'b0;
  int                    pending;
  int                    err_count;
  int                    sent        = 0;
  int                    stall_cycles = 0;

  always #5 clk = ~clk;

  text_console_char_writer_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tccw_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pending     (pending),
    .err_count   (err_count)
  );

  always @(posedge clk) begin
    if (steady) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 26);
  end

  // no beat on either stream for too long means the block is hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] code,
                          input logic [RIDX_W-1:0] ridx);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[CHAR_W-1:0] = code;
    word[CHAR_W +: RIDX_W] = ridx;
    if (!steady) begin
      while ($urandom_range(99) < 26) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd != CMD_UNUSED) sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    wait_drained();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // printable text, colons frequent so backspaces hit them
  function automatic logic [CHAR_W-1:0] text_byte();
    if ($urandom_range(7) == 0) return CH_COLON;
    return CHAR_W'($urandom_range(8'hFF, 8'h20));
  endfunction

  function automatic logic [RIDX_W-1:0] read_index();
    if ($urandom_range(9) == 0) return RIDX_W'($urandom_range(2047, CELL_COUNT));
    return RIDX_W'($urandom_range(CELL_COUNT - 1));
  endfunction

  function automatic logic [CHAR_W-1:0] any_byte();
    return CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [RIDX_W-1:0] any_index();
    return RIDX_W'($urandom_range(2047));
  endfunction

  function automatic logic [CMD_W-1:0] any_cmd();
    return CMD_W'($urandom_range(3));
  endfunction

  task automatic run_burst();
    int pick;
    pick = $urandom_range(99);
    if (pick < 33) begin
      repeat ($urandom_range(COLUMNS - 1)) send_cmd(CMD_PUT, text_byte(), any_index());
      send_cmd(CMD_PUT, CH_NEWLINE, any_index());
    end else if (pick < 43) begin
      repeat ($urandom_range(2 * COLUMNS + 10, COLUMNS))
        send_cmd(CMD_PUT, text_byte(), any_index());
    end else if (pick < 55) begin
      // fill one whole row; on the bottom row this leaves the cursor past the end
      send_cmd(CMD_PUT, CH_NEWLINE, any_index());
      repeat (COLUMNS) send_cmd(CMD_PUT, text_byte(), any_index());
      case ($urandom_range(3))
        0: send_cmd(CMD_PUT, CH_NEWLINE, any_index());
        1: send_cmd(CMD_PUT, CH_BACKSPACE, any_index());
        2: send_cmd(CMD_PUT, text_byte(), any_index());
        default: send_cmd(CMD_READ, any_byte(), RIDX_W'(CELL_COUNT - 1));
      endcase
    end else if (pick < 67) begin
      if ($urandom_range(2) == 0) send_cmd(CMD_PUT, CH_COLON, any_index());
      repeat ($urandom_range(6, 1)) send_cmd(CMD_PUT, CH_BACKSPACE, any_index());
    end else if (pick < 82) begin
      repeat ($urandom_range(6, 1)) send_cmd(CMD_READ, any_byte(), read_index());
    end else if (pick < 95) begin
      repeat ($urandom_range(4, 1)) send_cmd(CMD_PUT, CH_NEWLINE, any_index());
    end else if (pick < 97) begin
      send_cmd(CMD_CLEAR, any_byte(), any_index());
    end else begin
      repeat ($urandom_range(4, 1))
        send_cmd(any_cmd(), any_byte(), any_index());
    end
  endtask

  initial begin
    logic [ATTR_W-1:0] attr_plan [PHASES];
    attr_plan[0] = 8'hFF;
    attr_plan[1] = 8'h00;
    attr_plan[2] = ATTR_W'($urandom_range(255));
    attr_plan[3] = ATTR_W'($urandom_range(255));
    attr_plan[4] = 8'h80;
    attr_plan[5] = ATTR_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset attribute
    send_cmd(CMD_READ, 8'h00, 11'd0);
    send_cmd(CMD_READ, 8'hFF, 11'h7FF);           // out of range
    send_cmd(CMD_READ, 8'h00, RIDX_W'(CELL_COUNT - 1));
    send_cmd(CMD_READ, 8'h00, RIDX_W'(CELL_COUNT));
    send_cmd(CMD_PUT, CH_BACKSPACE, 11'd0);       // refused at cell zero
    send_cmd(CMD_PUT, 8'h41, 11'h7FF);
    send_cmd(CMD_PUT, CH_COLON, 11'd0);
    send_cmd(CMD_PUT, CH_BACKSPACE, 11'd0);       // refused at colon
    send_cmd(CMD_PUT, 8'hFF, 11'd0);
    send_cmd(CMD_PUT, 8'h00, 11'd0);
    send_cmd(CMD_PUT, CH_BACKSPACE, 11'd0);
    send_cmd(CMD_READ, 8'h00, 11'd3);
    send_cmd(CMD_READ, 8'h00, 11'd2);
    send_cmd(CMD_PUT, CH_NEWLINE, 11'd0);
    send_cmd(CMD_PUT, CH_BACKSPACE, 11'd0);       // back across a row boundary
    send_cmd(CMD_UNUSED, 8'hFF, 11'h7FF);
    send_cmd(CMD_READ, 8'h00, RIDX_W'(COLUMNS - 1));
    send_cmd(CMD_CLEAR, 8'h00, 11'd0);
    send_cmd(CMD_READ, 8'h00, 11'd1);

    for (int p = 0; p < PHASES; p++) begin
      write_attr(attr_plan[p]);
      steady <= (p == 2);
      while (sent < ((p + 1) * ITEM_COUNT) / PHASES) run_burst();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
